// ===== design/jpeg_marker_segment_deframer_assert.svh =====
// assertion macros used by the deframer checker
`ifndef JPEG_MARKER_SEGMENT_DEFRAMER_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_DEFRAMER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define JMSD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("jmsd assertion failed");

// next-cycle implication, off while reset is asserted
`define JMSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("jmsd assertion failed");

`endif

// ===== design/jmsd_pkg.sv =====
package jmsd_pkg;

	localparam logic [7:0]  MARKER_PREFIX   = 8'hFF;
	localparam logic [7:0]  MARKER_MIN      = 8'hC0;
	localparam logic [7:0]  MARKER_TEM      = 8'h01;
	localparam logic [7:0]  MARKER_RST0     = 8'hD0;
	localparam logic [7:0]  MARKER_EOI      = 8'hD9;
	localparam logic [7:0]  MARKER_SOF_LAST = 8'hCF;
	localparam logic [7:0]  MARKER_DHT      = 8'hC4;
	localparam logic [7:0]  MARKER_JPG      = 8'hC8;
	localparam logic [7:0]  MARKER_DAC      = 8'hCC;
	localparam logic [7:0]  MARKER_APP0     = 8'hE0;
	localparam logic [7:0]  MARKER_APP15    = 8'hEF;
	localparam logic [15:0] LEN_FIELD_BYTES = 16'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		KIND_STANDALONE = 3'd0,
		KIND_HEADER     = 3'd1,
		KIND_PAYLOAD    = 3'd2,
		KIND_BADLEN     = 3'd3,
		KIND_TRUNC      = 3'd4
	} result_kind_t;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   marker;
		logic [7:0]   payload;
		logic [15:0]  left;
		logic         last;
	} seg_word_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

	function automatic logic is_sof(input logic [7:0] m);
		return (m >= MARKER_MIN) && (m <= MARKER_SOF_LAST) &&
			(m != MARKER_DHT) && (m != MARKER_JPG) && (m != MARKER_DAC);
	endfunction

	function automatic logic is_app(input logic [7:0] m);
		return (m >= MARKER_APP0) && (m <= MARKER_APP15);
	endfunction

	function automatic logic is_standalone(input logic [7:0] m);
		return (m == MARKER_TEM) || ((m >= MARKER_RST0) && (m <= MARKER_EOI));
	endfunction

endpackage

// ===== design/jmsd_channels.sv =====
interface jmsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       stream_end;

	modport source (output valid, output byte_value, output stream_end, input ready);
	modport sink (input valid, input byte_value, input stream_end, output ready);
endinterface

interface jmsd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [7:0]  marker_code;
	logic [7:0]  payload_value;
	logic [15:0] bytes_left;
	logic        is_frame_start;
	logic        is_app_segment;
	logic        last_of_segment;

	modport source (output valid, output result_kind, output marker_code,
		output payload_value, output bytes_left, output is_frame_start,
		output is_app_segment, output last_of_segment, input ready);
	modport sink (input valid, input result_kind, input marker_code,
		input payload_value, input bytes_left, input is_frame_start,
		input is_app_segment, input last_of_segment, output ready);
endinterface

interface jmsd_cfg_if;
	logic valid;
	logic ready;
	logic emit_payload;

	modport source (output valid, output emit_payload, input ready);
	modport sink (input valid, input emit_payload, output ready);
endinterface

// ===== design/jmsd_front.sv =====
module jmsd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	jmsd_byte_if.sink               in_ch,
	jmsd_cfg_if.sink                cfg,
	input  jmsd_pkg::queue_status_t q_status,
	output logic                    push,
	output jmsd_pkg::seg_word_t     push_word
);
	import jmsd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_GOTFF = 3'd1,
		PH_LENHI = 3'd2,
		PH_LENLO = 3'd3,
		PH_DATA  = 3'd4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  marker_q, marker_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] remaining_q, remaining_d;
	logic        emit_payload_q;
	logic        accept;
	logic        hit;
	logic [15:0] seg_len;
	logic [15:0] rem_dec;
	seg_word_t   word;
	logic [7:0]  b;

	assign in_ch.ready = !q_status.full;
	assign cfg.ready   = 1'b1;
	assign accept      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.byte_value;
	assign seg_len     = {len_hi_q, b};
	assign rem_dec     = (remaining_q != '0) ? remaining_q - 16'd1 : remaining_q;

	always_comb begin
		phase_d     = phase_q;
		marker_d    = marker_q;
		len_hi_d    = len_hi_q;
		remaining_d = remaining_q;
		hit         = 1'b0;
		word        = '0;
		word.kind   = KIND_STANDALONE;
		unique case (phase_q)
			PH_GOTFF: begin
				priority if (b == MARKER_PREFIX) begin
					// fill bytes keep us waiting for the marker
					phase_d = PH_GOTFF;
				end else if (is_standalone(b)) begin
					marker_d    = b;
					hit         = 1'b1;
					word.kind   = KIND_STANDALONE;
					word.marker = b;
					word.last   = 1'b1;
					phase_d     = PH_HUNT;
				end else if (b < MARKER_MIN) begin
					phase_d = PH_HUNT;
				end else begin
					marker_d = b;
					if (in_ch.stream_end) begin
						hit       = 1'b1;
						word.kind = KIND_TRUNC;
						word.last = 1'b1;
					end
					phase_d = PH_LENHI;
				end
			end
			PH_LENHI: begin
				len_hi_d = b;
				if (in_ch.stream_end) begin
					hit       = 1'b1;
					word.kind = KIND_TRUNC;
					word.last = 1'b1;
				end
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				hit         = 1'b1;
				word.marker = marker_q;
				if (seg_len < LEN_FIELD_BYTES) begin
					remaining_d = '0;
					word.kind   = KIND_BADLEN;
					word.last   = 1'b1;
					phase_d     = PH_HUNT;
				end else begin
					remaining_d = seg_len - LEN_FIELD_BYTES;
					word.kind   = KIND_HEADER;
					word.left   = remaining_d;
					word.last   = (remaining_d == '0);
					phase_d     = (remaining_d == '0) ? PH_HUNT : PH_DATA;
				end
			end
			PH_DATA: begin
				remaining_d  = rem_dec;
				hit          = emit_payload_q;
				word.kind    = KIND_PAYLOAD;
				word.marker  = marker_q;
				word.payload = b;
				word.left    = rem_dec;
				word.last    = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = (b == MARKER_PREFIX) ? PH_GOTFF : PH_HUNT;
			end
		endcase
		// end of stream always drops back to hunting
		if (in_ch.stream_end) begin
			phase_d     = PH_HUNT;
			remaining_d = '0;
		end
	end

	assign push      = accept && hit;
	assign push_word = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			marker_q       <= '0;
			len_hi_q       <= '0;
			remaining_q    <= '0;
			emit_payload_q <= 1'b1;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				marker_q    <= marker_d;
				len_hi_q    <= len_hi_d;
				remaining_q <= remaining_d;
			end
			if (cfg.valid && cfg.ready) begin
				emit_payload_q <= cfg.emit_payload;
			end
		end
	end

endmodule

// ===== design/jmsd_queue.sv =====
module jmsd_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  jmsd_pkg::seg_word_t     push_word,
	input  logic                    pop,
	output jmsd_pkg::seg_word_t     head_word,
	output jmsd_pkg::queue_status_t status
);
	import jmsd_pkg::*;

	seg_word_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign status.full      = (count_q == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign status.not_empty = (count_q != '0);
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;
	assign head_word        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/jmsd_back.sv =====
module jmsd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  jmsd_pkg::seg_word_t     head_word,
	input  jmsd_pkg::queue_status_t q_status,
	output logic                    pop,
	jmsd_result_if.source           out_ch
);
	import jmsd_pkg::*;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  marker_q;
	logic [7:0]  payload_q;
	logic [15:0] left_q;
	logic        sof_q;
	logic        app_q;
	logic        last_q;

	// load a new word whenever the output register is empty or being drained
	assign pop = q_status.not_empty && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// truncation carries marker zero, so the flags drop out by themselves
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= head_word.kind;
			marker_q  <= head_word.marker;
			payload_q <= head_word.payload;
			left_q    <= head_word.left;
			sof_q     <= is_sof(head_word.marker);
			app_q     <= is_app(head_word.marker);
			last_q    <= head_word.last;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.result_kind     = kind_q;
	assign out_ch.marker_code     = marker_q;
	assign out_ch.payload_value   = payload_q;
	assign out_ch.bytes_left      = left_q;
	assign out_ch.is_frame_start  = sof_q;
	assign out_ch.is_app_segment  = app_q;
	assign out_ch.last_of_segment = last_q;

endmodule

// ===== design/jpeg_marker_segment_deframer.sv =====
// JPEG marker segment deframer: takes one stream byte per word and gives at most one
// result word per byte (standalone marker, segment header, payload byte, bad length or
// truncation). A byte can be accepted every cycle while the queue is not full. The
// byte-side state machine decides each result combinationally, and a four-entry queue
// in front of the output register lets the input keep flowing for up to four results
// while the output is stalled; once it fills, ready drops. The emit_payload register
// may be written only while no result is outstanding.
module jpeg_marker_segment_deframer (
	input  logic          clk,
	input  logic          arst_n,
	jmsd_byte_if.sink     in_ch,
	jmsd_cfg_if.sink      cfg,
	jmsd_result_if.source out_ch
);
	import jmsd_pkg::*;

	queue_status_t q_status;
	logic          push;
	seg_word_t     push_word;
	logic          pop;
	seg_word_t     head_word;

	jmsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg),
		.q_status  (q_status),
		.push      (push),
		.push_word (push_word)
	);

	jmsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.status    (q_status)
	);

	jmsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_word (head_word),
		.q_status  (q_status),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

// ===== design/jmsd_checker.sv =====
`include "jpeg_marker_segment_deframer_assert.svh"

module jmsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_kind,
	input logic [7:0]  marker_code,
	input logic [7:0]  payload_value,
	input logic [15:0] bytes_left,
	input logic        is_frame_start,
	input logic        last_of_segment
);
	import jmsd_pkg::*;

	logic        kind_trunc;
	logic        kind_payload;
	logic        kind_closed;

	assign kind_trunc   = (result_kind == KIND_TRUNC);
	assign kind_payload = (result_kind == KIND_PAYLOAD);
	assign kind_closed  = (result_kind == KIND_STANDALONE) || (result_kind == KIND_BADLEN);

	// a stalled word stays put until taken
	`JMSD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(bytes_left) && $stable(payload_value))

	// truncation carries nothing but the end mark
	`JMSD_ASSERT_NOW(a_trunc_empty, clk, arst_n, out_valid && kind_trunc, marker_code == 8'h00 && bytes_left == 16'h0000 && !is_frame_start && last_of_segment)

	// standalone and bad length words close their segment with nothing left
	`JMSD_ASSERT_NOW(a_closed_zero, clk, arst_n, out_valid && kind_closed, bytes_left == 16'h0000 && last_of_segment)

	// only payload words carry a data byte, and last is set exactly when nothing is left
	`JMSD_ASSERT_NOW(a_payload_only, clk, arst_n, out_valid && !kind_payload, payload_value == 8'h00)
	`JMSD_ASSERT_NOW(a_last_left, clk, arst_n, out_valid && (kind_payload || result_kind == KIND_HEADER), last_of_segment == (bytes_left == 16'h0000))

endmodule

bind jpeg_marker_segment_deframer jmsd_checker u_jmsd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.result_kind     (out_ch.result_kind),
	.marker_code     (out_ch.marker_code),
	.payload_value   (out_ch.payload_value),
	.bytes_left      (out_ch.bytes_left),
	.is_frame_start  (out_ch.is_frame_start),
	.last_of_segment (out_ch.last_of_segment)
);

// ===== bench/jmsd_result_monitor.sv =====
`timescale 1ns / 100ps

module jmsd_result_monitor
	import jmsd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	jmsd_byte_if   in_ch,
	jmsd_cfg_if    cfg,
	jmsd_result_if out_ch,
	output int     mismatches,
	output int     pending,
	output int     compared
);

	typedef enum logic [2:0] {
		SEEK_FF,
		SAW_FF,
		LEN_HI,
		LEN_LO,
		IN_PAYLOAD
	} parse_phase_t;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   marker;
		logic [7:0]   payload;
		logic [15:0]  left;
		logic         frame_start;
		logic         app_seg;
		logic         last;
	} segment_report_t;

	parse_phase_t    phase;
	logic [7:0]      seg_marker;
	logic [7:0]      len_hi;
	logic [15:0]     left_count;
	logic            emit_on;
	segment_report_t pending_reports[$];

	// c4, c8 and cc share the sof nibble but are table and extension markers
	function automatic logic frame_start_code(input logic [7:0] m);
		return (m[7:4] == MARKER_MIN[7:4]) && !(m[1:0] == 2'b00 && m[3:2] != 2'b00);
	endfunction

	function automatic logic app_code(input logic [7:0] m);
		return m[7:4] == MARKER_APP0[7:4];
	endfunction

	function automatic logic standalone_code(input logic [7:0] m);
		return (m == MARKER_TEM) || (m >= MARKER_RST0 && m <= MARKER_EOI);
	endfunction

	function automatic segment_report_t make_report(input result_kind_t kind,
		input logic [7:0] marker, input logic [7:0] payload, input logic [15:0] left,
		input logic flags, input logic last);
		segment_report_t r;
		r.kind        = kind;
		r.marker      = marker;
		r.payload     = payload;
		r.left        = left;
		r.frame_start = flags && frame_start_code(marker);
		r.app_seg     = flags && app_code(marker);
		r.last        = last;
		return r;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic fin);
		segment_report_t r;
		logic            have;
		logic [15:0]     seg_len;
		have = 1'b0;
		r = '0;
		case (phase)
			SAW_FF: begin
				// further 0xff bytes are fill and keep us here
				if (b != MARKER_PREFIX) begin
					if (standalone_code(b)) begin
						seg_marker = b;
						r = make_report(KIND_STANDALONE, b, 8'h00, 16'h0000, 1'b1, 1'b1);
						have = 1'b1;
						phase = SEEK_FF;
					end else if (b < MARKER_MIN) begin
						phase = SEEK_FF;
					end else begin
						seg_marker = b;
						if (fin) begin
							r = make_report(KIND_TRUNC, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1);
							have = 1'b1;
						end
						phase = LEN_HI;
					end
				end
			end
			LEN_HI: begin
				len_hi = b;
				if (fin) begin
					r = make_report(KIND_TRUNC, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1);
					have = 1'b1;
				end
				phase = LEN_LO;
			end
			LEN_LO: begin
				seg_len = {len_hi, b};
				if (seg_len < LEN_FIELD_BYTES) begin
					left_count = 16'h0000;
					r = make_report(KIND_BADLEN, seg_marker, 8'h00, 16'h0000, 1'b1, 1'b1);
					phase = SEEK_FF;
				end else begin
					left_count = seg_len - LEN_FIELD_BYTES;
					r = make_report(KIND_HEADER, seg_marker, 8'h00, left_count, 1'b1,
						left_count == 16'h0000);
					phase = (left_count == 16'h0000) ? SEEK_FF : IN_PAYLOAD;
				end
				have = 1'b1;
			end
			IN_PAYLOAD: begin
				if (left_count != 16'h0000)
					left_count = left_count - 16'h0001;
				if (emit_on) begin
					r = make_report(KIND_PAYLOAD, seg_marker, b, left_count, 1'b1,
						left_count == 16'h0000);
					have = 1'b1;
				end
				if (left_count == 16'h0000)
					phase = SEEK_FF;
			end
			default: begin
				phase = (b == MARKER_PREFIX) ? SAW_FF : SEEK_FF;
			end
		endcase
		// end of stream always drops back to hunting, a cut payload goes unreported
		if (fin) begin
			phase = SEEK_FF;
			left_count = 16'h0000;
		end
		if (have)
			pending_reports.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_word();
		segment_report_t want;
		if (pending_reports.size() == 0) begin
			$error("result word with none expected: kind %0d marker %0h",
				out_ch.result_kind, out_ch.marker_code);
			mismatches++;
		end else begin
			want = pending_reports.pop_front();
			compared++;
			check_field("result_kind", 16'(want.kind), 16'(out_ch.result_kind));
			check_field("marker_code", 16'(want.marker), 16'(out_ch.marker_code));
			check_field("payload_value", 16'(want.payload), 16'(out_ch.payload_value));
			check_field("bytes_left", want.left, out_ch.bytes_left);
			check_field("is_frame_start", 16'(want.frame_start), 16'(out_ch.is_frame_start));
			check_field("is_app_segment", 16'(want.app_seg), 16'(out_ch.is_app_segment));
			check_field("last_of_segment", 16'(want.last), 16'(out_ch.last_of_segment));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = SEEK_FF;
			seg_marker = 8'h00;
			len_hi = 8'h00;
			left_count = 16'h0000;
			emit_on = 1'b1;
			pending_reports.delete();
			mismatches = 0;
			pending = 0;
			compared = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				emit_on = cfg.emit_payload;
			// outgoing word first so a spurious one cannot match this cycle's byte
			if (out_ch.valid && out_ch.ready)
				compare_word();
			if (in_ch.valid && in_ch.ready)
				parse_byte(in_ch.byte_value, in_ch.stream_end);
			pending = pending_reports.size();
		end
	end

endmodule

// ===== bench/tb_jpeg_marker_segment_deframer.sv =====
`timescale 1ns / 100ps

module tb_jpeg_marker_segment_deframer;
	import jmsd_pkg::*;

	localparam int RUN_LIMIT  = 200000;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 8;
	localparam int DRAIN_MAX  = 5000;
	localparam int PHASE_LEN  = 350;

	logic clk = 1'b0;
	logic arst_n;

	jmsd_byte_if   in_ch();
	jmsd_cfg_if    cfg();
	jmsd_result_if out_ch();

	int mismatches;
	int pending;
	int compared;
	int bytes_sent;
	int cfg_writes;
	int hold_requests;
	int holds_done;
	bit src_gaps;
	bit sink_gaps;

	always #6 clk = ~clk;

	jpeg_marker_segment_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.out_ch (out_ch)
	);

	jmsd_result_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg),
		.out_ch     (out_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared)
	);

	// result side: random stalls, plus a long hold-off whenever one is requested
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done < hold_requests) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				holds_done++;
			end else if (sink_gaps && $urandom_range(99) < 8) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while (src_gaps && $urandom_range(99) < 8) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.byte_value <= b;
		in_ch.stream_end <= fin;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	task automatic drain();
		int k;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		for (k = 0; k < DRAIN_MAX && pending != 0; k++)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_emit(input logic v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.emit_payload <= v;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic send_segment();
		logic [7:0]  m;
		logic [15:0] seg_len;
		int          pick;
		int          n_pay;
		int          end_at;
		int          k;
		bit          stopped;
		send_byte(MARKER_PREFIX, 1'b0);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(3, 1)) send_byte(MARKER_PREFIX, 1'b0);
		do m = 8'($urandom_range(8'hFE, MARKER_MIN));
		while (m >= MARKER_RST0 && m <= MARKER_EOI);
		pick = $urandom_range(99);
		if (pick < 4) begin
			send_byte(m, 1'b1);
		end else if (pick < 8) begin
			send_byte(m, 1'b0);
			send_byte(8'($urandom_range(255)), 1'b1);
		end else begin
			send_byte(m, 1'b0);
			if (pick < 14)
				seg_len = 16'($urandom_range(1, 0));
			else if (pick < 17)
				seg_len = 16'hFFFF;
			else if (pick < 20)
				seg_len = 16'($urandom_range(16'hFFFE, 300));
			else
				seg_len = 16'($urandom_range(14, 2));
			send_byte(seg_len[15:8], 1'b0);
			if (pick >= 14 && pick < 20) begin
				// long segment: a few bytes, then the stream ends mid-payload
				send_byte(seg_len[7:0], 1'b0);
				n_pay = $urandom_range(12, 1);
				for (k = 1; k <= n_pay; k++)
					send_byte(8'($urandom_range(255)), k == n_pay);
			end else begin
				n_pay = (seg_len < LEN_FIELD_BYTES) ? 0 : int'(seg_len) - 2;
				end_at = ($urandom_range(9) == 0) ? $urandom_range(n_pay) : -1;
				send_byte(seg_len[7:0], end_at == 0);
				stopped = (end_at == 0);
				for (k = 1; k <= n_pay && !stopped; k++) begin
					send_byte(8'($urandom_range(255)), end_at == k);
					stopped = (end_at == k);
				end
			end
		end
	endtask

	task automatic send_chunk();
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 55) begin
			send_segment();
		end else if (pick < 70) begin
			v = $urandom_range(10);
			send_byte(MARKER_PREFIX, 1'b0);
			send_byte((v == 10) ? MARKER_TEM : MARKER_RST0 + 8'(v),
				$urandom_range(99) < 3);
		end else if (pick < 80) begin
			send_byte(MARKER_PREFIX, 1'b0);
			send_byte(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(8'hBF)),
				$urandom_range(99) < 3);
		end else begin
			repeat ($urandom_range(4, 1))
				send_byte(8'($urandom_range(255)), $urandom_range(99) < 2);
		end
	endtask

	task automatic run_stream(input int n);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n)
			send_chunk();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.byte_value = 8'h00;
		in_ch.stream_end = 1'b0;
		cfg.valid = 1'b0;
		cfg.emit_payload = 1'b0;
		bytes_sent = 0;
		cfg_writes = 0;
		hold_requests = 0;
		holds_done = 0;
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// soi, fill before tem, stuffed zero
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(8'hD8, 1'b0);
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(MARKER_TEM, 1'b0);
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(8'h00, 1'b0);
		// sof0 with one payload word
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(MARKER_MIN, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h7E, 1'b0);
		// empty app1, then a zero length
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(8'hE1, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		// stream ends on the marker, then on the high length byte
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(MARKER_DHT, 1'b1);
		send_byte(MARKER_PREFIX, 1'b0);
		send_byte(8'hDB, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain();

		write_emit(1'b0);
		run_stream(PHASE_LEN);
		drain();

		write_emit(1'b1);
		hold_requests++;
		run_stream(PHASE_LEN);
		drain();

		// no idling on either side here
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		run_stream(PHASE_LEN);
		drain();
		src_gaps = 1'b1;
		sink_gaps = 1'b1;

		write_emit(1'b0);
		run_stream(PHASE_LEN / 2);
		drain();
		write_emit(1'b1);
		run_stream(PHASE_LEN / 2);
		drain();

		if (pending != 0)
			$error("%0d expected result words never arrived", pending);
		$display("run covered %0d stream bytes and %0d result words, %0d payload mode writes",
			bytes_sent, compared, cfg_writes);
		$display("with random stalls, a gap-free stretch and a %0d-cycle output hold-off",
			LONG_HOLD);
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
